>>> hw/rtl/ows_pkg.sv
// Shared types and constants for the 1-Wire ROM search engine.
// No dependencies; every module of the block imports this package.
package ows_pkg;

   // Number of ROM address bits walked per search pass (8 to 64).
   localparam int ADDR_BITS = 64;
   localparam int IDX_W     = $clog2(ADDR_BITS);
   localparam int POS_W     = 7;
   localparam int FIELD_AW  = 64;

   // Operation codes of a request transaction
   localparam logic [1:0] OP_RESET   = 2'd0;
   localparam logic [1:0] OP_START   = 2'd1;
   localparam logic [1:0] OP_TRIPLET = 2'd2;

   // Status codes of a response transaction
   localparam logic [2:0] ST_DIRECTION  = 3'd0;
   localparam logic [2:0] ST_FOUND      = 3'd1;
   localparam logic [2:0] ST_NO_MORE    = 3'd2;
   localparam logic [2:0] ST_BUS_ERROR  = 3'd3;
   localparam logic [2:0] ST_NO_DEVICES = 3'd4;
   localparam logic [2:0] ST_RESET_DONE = 3'd5;

   typedef struct packed {
      logic [1:0]          op;
      logic [FIELD_AW-1:0] seed_address;
      logic [POS_W-1:0]    start_discrepancy;
      logic                id_bit;
      logic                complement_bit;
      logic                taken_direction;
      logic                triplet_failed;
   } req_type;

   typedef struct packed {
      logic [2:0]          status;
      logic                requested_direction;
      logic [POS_W-1:0]    bit_position;
      logic [FIELD_AW-1:0] device_address;
      logic                was_last_device;
   } rsp_type;

endpackage

>>> hw/rtl/ows_core.sv
// Search state registers and the single-pass update logic for one transaction.
// Depends on ows_pkg.
module ows_core import ows_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    item_fire,
   input  req_type item,
   output logic    has_result,
   output rsp_type result
);

   logic [ADDR_BITS-1:0] saved_addr_ff, saved_addr_in;
   logic [POS_W-1:0]     saved_disc_ff, saved_disc_in;
   logic                 done_ff, done_in;
   logic [ADDR_BITS-1:0] work_addr_ff, work_addr_in;
   logic [POS_W-1:0]     zero_branch_ff, zero_branch_in;
   logic [POS_W-1:0]     cur_bit_ff, cur_bit_in;
   logic                 pass_ff, pass_in;

   logic [IDX_W-1:0]     cur_idx;
   logic [IDX_W-1:0]     next_idx;
   logic [POS_W-1:0]     next_pos;
   logic [ADDR_BITS-1:0] work_addr_upd;
   logic [POS_W-1:0]     zero_branch_upd;

   assign cur_idx  = IDX_W'(cur_bit_ff - POS_W'(1));
   assign next_idx = IDX_W'(cur_bit_ff);
   assign next_pos = cur_bit_ff + POS_W'(1);

   // Address and discrepancy after taking this triplet's direction
   always_comb begin
      work_addr_upd          = work_addr_ff;
      work_addr_upd[cur_idx] = item.taken_direction;
      zero_branch_upd        = zero_branch_ff;
      if (!item.id_bit && !item.complement_bit && !item.taken_direction) begin
         zero_branch_upd = cur_bit_ff;
      end
   end

   always_comb begin
      saved_addr_in  = saved_addr_ff;
      saved_disc_in  = saved_disc_ff;
      done_in        = done_ff;
      work_addr_in   = work_addr_ff;
      zero_branch_in = zero_branch_ff;
      cur_bit_in     = cur_bit_ff;
      pass_in        = pass_ff;
      has_result     = 1'b0;
      result         = '0;
      if (item_fire) begin
         case (item.op)
            OP_RESET: begin
               saved_addr_in  = item.seed_address[ADDR_BITS-1:0];
               saved_disc_in  = item.start_discrepancy;
               done_in        = 1'b0;
               pass_in        = 1'b0;
               has_result     = 1'b1;
               result.status  = ST_RESET_DONE;
            end
            OP_START: begin
               has_result = 1'b1;
               if (done_ff) begin
                  pass_in       = 1'b0;
                  result.status = ST_NO_MORE;
               end else begin
                  work_addr_in        = saved_addr_ff;
                  zero_branch_in      = '0;
                  cur_bit_in          = POS_W'(1);
                  pass_in             = 1'b1;
                  result.status       = ST_DIRECTION;
                  result.bit_position = POS_W'(1);
                  if (POS_W'(1) < saved_disc_ff) begin
                     result.requested_direction = saved_addr_ff[0];
                  end else begin
                     result.requested_direction = (saved_disc_ff == POS_W'(1));
                  end
               end
            end
            OP_TRIPLET: begin
               if (pass_ff) begin
                  has_result = 1'b1;
                  if (item.triplet_failed) begin
                     pass_in             = 1'b0;
                     result.status       = ST_BUS_ERROR;
                     result.bit_position = cur_bit_ff;
                  end else if (item.id_bit && item.complement_bit) begin
                     pass_in             = 1'b0;
                     result.status       = ST_NO_DEVICES;
                     result.bit_position = cur_bit_ff;
                  end else begin
                     work_addr_in   = work_addr_upd;
                     zero_branch_in = zero_branch_upd;
                     if (cur_bit_ff >= POS_W'(ADDR_BITS)) begin
                        // End of pass: commit address and discrepancy
                        pass_in                = 1'b0;
                        saved_disc_in          = zero_branch_upd;
                        done_in                = (zero_branch_upd == '0);
                        saved_addr_in          = work_addr_upd;
                        result.status          = ST_FOUND;
                        result.device_address  = FIELD_AW'(work_addr_upd);
                        result.was_last_device = (zero_branch_upd == '0);
                     end else begin
                        cur_bit_in          = next_pos;
                        result.status       = ST_DIRECTION;
                        result.bit_position = next_pos;
                        if (next_pos < saved_disc_ff) begin
                           result.requested_direction = work_addr_upd[next_idx];
                        end else begin
                           result.requested_direction = (next_pos == saved_disc_ff);
                        end
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         saved_addr_ff  <= '0;
         saved_disc_ff  <= '0;
         done_ff        <= 1'b0;
         work_addr_ff   <= '0;
         zero_branch_ff <= '0;
         cur_bit_ff     <= '0;
         pass_ff        <= 1'b0;
      end else begin
         saved_addr_ff  <= saved_addr_in;
         saved_disc_ff  <= saved_disc_in;
         done_ff        <= done_in;
         work_addr_ff   <= work_addr_in;
         zero_branch_ff <= zero_branch_in;
         cur_bit_ff     <= cur_bit_in;
         pass_ff        <= pass_in;
      end
   end

endmodule

>>> hw/rtl/ows_rsp_stage.sv
// Response output register with valid/ready handshake.
// Depends on ows_pkg.
module ows_rsp_stage import ows_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    space,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   // Room for a new transaction when empty or being drained this cycle
   assign space = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (push) begin
         valid_in = 1'b1;
         data_in  = push_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

>>> hw/rtl/one_wire_rom_search_engine.sv
// Top level of the 1-Wire ROM search engine: input register, search core, response register.
// Depends on ows_pkg, ows_core and ows_rsp_stage.
//
//   Channel   Direction  Handshake             Payload
//   req_      in         req_valid/req_ready   req_data (req_type)
//   rsp_      out        rsp_valid/rsp_ready   rsp_data (rsp_type)
//
// Each request transaction is held in the input register, then its state update and
// response are computed combinationally into the response register, one transaction
// per cycle sustained while the response side does not stall.
// A triplet with no pass open and an unused op code produce no response.
// Synchronous reset clears all search state and both valid flags.
// A stalled response holds the input register; req_ready drops only when both are full.
module one_wire_rom_search_engine import ows_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff, in_item_in;
   logic    advance;
   logic    has_result;
   rsp_type result;
   logic    out_space;

   // Move the held transaction into the core when the response side has room
   assign advance   = in_valid_ff && out_space;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_item_in  = in_item_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_item_in  = req_data;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      in_item_ff <= in_item_in;
   end

   ows_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_fire  (advance),
      .item       (in_item_ff),
      .has_result (has_result),
      .result     (result)
   );

   ows_rsp_stage u_rsp (
      .clock     (clock),
      .reset     (reset),
      .push      (advance && has_result),
      .push_data (result),
      .space     (out_space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
